// ===== design/fpa_pkg.sv =====
// Shared types and constants for the fixed-point ALU with square root.
`default_nettype none
package fpa_pkg;

  // Operation codes carried in tuser.
  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_SUB    = 3'd1,
    CMD_MUL    = 3'd2,
    CMD_DIV    = 3'd3,
    CMD_SQUARE = 3'd4,
    CMD_ABS    = 3'd5,
    CMD_SQRT   = 3'd6
  } cmd_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SQ_CHECK,
    ST_DONE
  } state_t;

  localparam int unsigned MUL_STEPS = 64;
  localparam int unsigned DIV_STEPS = 128;
  localparam int unsigned CNT_W     = 7;

  // Two's complement magnitude; the most negative value maps to itself.
  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? (64'd0 - v) : v;
  endfunction

endpackage
`default_nettype wire

// ===== design/fixed_point_alu_with_sqrt.sv =====
// Top level of the signed 64-bit fixed-point ALU with iterative square root.
`default_nettype none
// One beat in gives one beat out. The block takes a new beat only when it is
// idle and holds it until its result has been placed in the output register.
// Add, subtract, absolute value, divide by zero, square root of a value at or
// below zero and the unused code go straight to ST_DONE. Multiply and square
// run a shift-add loop over one shared 65-bit adder: 64 steps.
// Divide runs a restoring loop over the same adder: 128 steps.
// Square root runs the convergence check and the averaging in ST_SQ_CHECK for
// at most SQRT_MAX_STEPS Newton steps, each that does not stop followed by one
// 128-step division unless the new estimate is zero. The output register lets
// the result wait for m_tready; the next beat is taken once it is loaded.
module fixed_point_alu_with_sqrt #(
  parameter int unsigned FRAC_BITS      = 32,
  parameter int unsigned SQRT_MAX_STEPS = 20
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  // Fields from bit 0 up: operand_a [63:0], operand_b [127:64].
  input  wire logic [127:0]  s_tdata,
  // Fields from bit 0 up: cmd [2:0].
  input  wire logic [2:0]    s_tuser,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  // Fields from bit 0 up: result [63:0].
  output logic [63:0]        m_tdata
);
  import fpa_pkg::*;

  state_t state, state_next;

  logic [2:0]       cmd;
  logic [63:0]      a_q;      // square root operand
  logic [63:0]      x_q;
  logic [63:0]      y_q;
  logic [CNT_W-1:0] scnt;     // Newton steps done
  logic [CNT_W-1:0] cnt;      // steps of the shared loop
  logic [127:0]     p;        // product, or numerator and quotient
  logic [63:0]      rem;
  logic [63:0]      dvs;      // divisor, or multiplicand
  logic             neg;
  logic [63:0]      rslt;

  // Control decoded from the state.
  logic accept, out_load, is_div, loop_last;

  // Shared adder.
  logic [64:0] ax, ay, r_sh;
  logic [65:0] sum;
  logic        ge;

  // Square root check.
  logic [63:0] diff, adist, xy_sum, xy_mag, half, x_new;
  logic [63:0] eps;
  logic        sq_stop;

  // Immediate operations.
  logic [63:0] op_a, op_b, imm;
  logic [127:0] p_mul;
  logic [127:0] prod_s;

  assign op_a = s_tdata[63:0];
  assign op_b = s_tdata[127:64];
  assign eps  = 64'd1 << (FRAC_BITS - 8);

  // Handshake and loop control decoded from the state.
  always_comb begin
    s_tready  = (state == ST_IDLE);
    accept    = s_tvalid && (state == ST_IDLE);
    out_load  = (state == ST_DONE) && (!m_tvalid || m_tready);
    is_div    = (state == ST_DIV);
    loop_last = is_div ? (cnt == CNT_W'(DIV_STEPS - 1)) : (cnt == CNT_W'(MUL_STEPS - 1));
  end

  // One adder: r - d for the divider, hi + multiplicand (when p[0] is set) for the multiplier.
  always_comb begin
    r_sh = {rem, p[127]};
    if (is_div) begin
      ax = r_sh;
      ay = ~{1'b0, dvs};
    end else begin
      ax = {1'b0, p[127:64]};
      ay = p[0] ? {1'b0, dvs} : 65'd0;
    end
    sum = {1'b0, ax} + {1'b0, ay} + {65'd0, is_div};
    ge  = sum[65];
  end

  // Product after this multiply step, and its signed value.
  always_comb begin
    p_mul  = {sum[64:0], p[63:1]};
    prod_s = neg ? (128'd0 - p_mul) : p_mul;
  end

  // Newton step pieces.
  always_comb begin
    diff    = x_q - y_q;
    adist   = mag64(diff);
    sq_stop = adist[63] || (adist <= eps) || (scnt == CNT_W'(SQRT_MAX_STEPS));
    xy_sum  = x_q + y_q;
    xy_mag  = mag64(xy_sum);
    half    = {1'b0, xy_mag[63:1]};
    x_new   = xy_sum[63] ? (64'd0 - half) : half;
  end

  // Results that need no loop.
  always_comb begin
    case (s_tuser)
      CMD_ADD:  imm = op_a + op_b;
      CMD_SUB:  imm = op_a - op_b;
      CMD_ABS:  imm = mag64(op_a);
      default:  imm = 64'd0;
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (s_tuser)
            CMD_MUL, CMD_SQUARE: state_next = ST_MUL;
            CMD_DIV:  state_next = (op_b == 64'd0) ? ST_DONE : ST_DIV;
            CMD_SQRT: state_next = (op_a[63] || op_a == 64'd0) ? ST_DONE : ST_SQ_CHECK;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL: begin
        if (loop_last) state_next = ST_DONE;
      end
      ST_DIV: begin
        if (loop_last) state_next = (cmd == CMD_SQRT) ? ST_SQ_CHECK : ST_DONE;
      end
      ST_SQ_CHECK: begin
        if (sq_stop) state_next = ST_DONE;
        else if (x_new != 64'd0) state_next = ST_DIV;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= rslt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd  <= s_tuser;
          a_q  <= op_a;
          x_q  <= op_a;
          y_q  <= 64'd1 << FRAC_BITS;
          scnt <= '0;
          cnt  <= '0;
          rem  <= 64'd0;
          rslt <= imm;
          case (s_tuser)
            CMD_MUL: begin
              dvs <= mag64(op_a);
              p   <= {64'd0, mag64(op_b)};
              neg <= op_a[63] ^ op_b[63];
            end
            CMD_SQUARE: begin
              dvs <= mag64(op_a);
              p   <= {64'd0, mag64(op_a)};
              neg <= 1'b0;
            end
            default: begin
              dvs <= mag64(op_b);
              p   <= {64'd0, mag64(op_a)} << FRAC_BITS;
              neg <= op_a[63] ^ op_b[63];
            end
          endcase
        end
      end
      ST_MUL: begin
        p   <= p_mul;
        cnt <= cnt + CNT_W'(1);
        if (loop_last) rslt <= prod_s[FRAC_BITS +: 64];
      end
      ST_DIV: begin
        rem <= ge ? sum[63:0] : r_sh[63:0];
        p   <= {p[126:0], ge};
        cnt <= cnt + CNT_W'(1);
        if (loop_last) begin
          if (cmd == CMD_SQRT) y_q <= neg ? (64'd0 - {p[62:0], ge}) : {p[62:0], ge};
          else rslt <= neg ? (64'd0 - {p[62:0], ge}) : {p[62:0], ge};
        end
      end
      ST_SQ_CHECK: begin
        if (sq_stop) begin
          rslt <= x_q;
        end else begin
          x_q  <= x_new;
          scnt <= scnt + CNT_W'(1);
          cnt  <= '0;
          rem  <= 64'd0;
          dvs  <= mag64(x_new);
          p    <= {64'd0, a_q} << FRAC_BITS;
          neg  <= x_new[63];
          if (x_new == 64'd0) y_q <= 64'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the fixed-point ALU with square root.
`default_nettype none
module tb;
  import fpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAC  = 32;
  localparam int unsigned STEPS = 20;
  localparam int unsigned NUM_RANDOM = 420;
  // Worst case: every beat a square root, plus stalls and gaps.
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] a;
    logic [63:0] b;
  } alu_op_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [127:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;

  fixed_point_alu_with_sqrt #(.FRAC_BITS(FRAC), .SQRT_MAX_STEPS(STEPS)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  alu_op_t     pending_ops[$];
  logic [63:0] expected_results[$];
  int          errors = 0;
  bit          stim_done = 1'b0;
  bit          hold_for_drain = 1'b0;
  longint unsigned cycles = 0;

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  // Full signed product, floor-shifted by the fraction width.
  function automatic logic [63:0] fx_product(input logic [63:0] a, input logic [63:0] b);
    logic signed [127:0] p;
    p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
    p = p >>> FRAC;
    return p[63:0];
  endfunction

  // Quotient of the magnitudes, sign applied afterwards; zero for a zero divisor.
  function automatic logic [63:0] fx_quotient(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] num;
    logic [127:0] q;
    if (b == 64'd0) return 64'd0;
    num = {64'd0, magnitude(a)} << FRAC;
    q = num / {64'd0, magnitude(b)};
    return (a[63] ^ b[63]) ? (64'd0 - q[63:0]) : q[63:0];
  endfunction

  function automatic logic [63:0] fx_root(input logic [63:0] a);
    logic [63:0] x, y, diff, distance;
    x = a;
    y = 64'd1 << FRAC;
    if (a == 64'd0 || a[63]) return 64'd0;
    for (int i = 0; i < STEPS; i++) begin
      diff = x - y;
      distance = magnitude(diff);
      // A wrapped negative distance stops the iteration just like convergence.
      if (distance[63] || distance <= (64'd1 << (FRAC - 8))) break;
      x = fx_quotient(x + y, 64'd2 << FRAC);
      y = fx_quotient(a, x);
    end
    return x;
  endfunction

  function automatic logic [63:0] alu_result(input alu_op_t op);
    case (op.cmd)
      CMD_ADD:    return op.a + op.b;
      CMD_SUB:    return op.a - op.b;
      CMD_MUL:    return fx_product(op.a, op.b);
      CMD_DIV:    return fx_quotient(op.a, op.b);
      CMD_SQUARE: return fx_product(op.a, op.a);
      CMD_ABS:    return magnitude(op.a);
      CMD_SQRT:   return fx_root(op.a);
      default:    return 64'd0;
    endcase
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    // Bias toward small magnitudes and near-one values so results are meaningful.
    case ($urandom_range(0, 5))
      0: v = $signed(v) >>> $urandom_range(0, 63);
      1: v = {{32{v[63]}}, v[31:0]};
      2: v = (64'd1 << FRAC) + {{56{v[7]}}, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  // Driver: bursts of random length separated by random gaps. A beat that is
  // not taken yet is held with tvalid high and its data steady until it is accepted.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(alu_result({s_tuser, s_tdata[63:0], s_tdata[127:64]}));
        void'(pending_ops.pop_front());
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (pending_ops.size() > 0 && gap_left == 0 && !hold_for_drain) begin
          alu_op_t nxt;
          nxt = pending_ops[0];
          s_tvalid <= 1'b1;
          s_tuser  <= nxt.cmd;
          s_tdata  <= {nxt.b, nxt.a};
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: the receiver is ready for part of each period, else stalls at random.
  int stall_phase = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: result=%h", m_tdata);
          errors++;
        end else begin
          logic [63:0] exp_r;
          exp_r = expected_results.pop_front();
          if (m_tdata !== exp_r) begin
            $error("result mismatch: expected %h actual %h", exp_r, m_tdata);
            errors++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 97;
      if (stall_phase < 30) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 2) != 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic add_op(input cmd_t c, input logic [63:0] a, input logic [63:0] b);
    pending_ops.push_back('{cmd: c, a: a, b: b});
  endtask

  initial begin
    localparam logic [63:0] MAXP = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ONE  = 64'h1_0000_0000;
    cmd_t ops[7];
    ops = '{CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_SQUARE, CMD_ABS, CMD_SQRT};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: wraps, divide by zero, abs of the most negative value,
    // sqrt of zero and negatives, sqrt of huge values, and the unused code.
    add_op(CMD_ADD, MAXP, ONE);
    add_op(CMD_SUB, MINN, 64'd1);
    add_op(CMD_MUL, MINN, MINN);
    add_op(CMD_MUL, MAXP, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(CMD_DIV, ONE, 64'd0);
    add_op(CMD_DIV, MINN, 64'hFFFF_FFFF_FFFF_FFFF);
    add_op(CMD_DIV, MAXP, 64'd1);
    add_op(CMD_DIV, 64'hFFFF_FFFF_0000_0000, 64'h3_0000_0000);
    add_op(CMD_SQUARE, MINN, 64'd0);
    add_op(CMD_SQUARE, 64'hFFFF_FFFF_8000_0000, MAXP);
    add_op(CMD_ABS, MINN, MAXP);
    add_op(CMD_ABS, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
    add_op(CMD_SQRT, 64'd0, 64'd5);
    add_op(CMD_SQRT, MINN, 64'd0);
    add_op(CMD_SQRT, 64'd1, 64'd0);
    add_op(CMD_SQRT, MAXP, 64'd0);
    add_op(CMD_SQRT, 64'h4_0000_0000, 64'd0);
    add_op(CMD_SQRT, ONE, 64'd0);
    pending_ops.push_back('{cmd: 3'd7, a: MAXP, b: MINN});
    add_op(CMD_ADD, 64'd0, 64'd0);

    for (int i = 0; i < NUM_RANDOM; i++) begin
      logic [2:0] c;
      c = (i % 53 == 0) ? 3'd7 : ops[$urandom_range(0, 6)];
      pending_ops.push_back('{cmd: c, a: rand64(), b: rand64()});
      // Halfway through, the sender holds off until the block has drained.
      if (i == NUM_RANDOM / 2) begin
        wait (pending_ops.size() == 0);
        hold_for_drain = 1'b1;
        wait (expected_results.size() == 0 && !s_tvalid);
        hold_for_drain = 1'b0;
      end
    end

    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (3000) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
